[rtl/core/lrt_pkg.sv]
package lrt_pkg;

  // Defaults for the top level parameters
  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 32;

  // Slot indexes are carried at this width; it covers the largest ENTRIES of 256
  localparam int SLOT_BITS = 8;

  // Field widths on the channels
  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TOUCH  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  // How the row of cells moves when a command is applied
  localparam logic [1:0] MV_NONE      = 2'd0;
  localparam logic [1:0] MV_ALL_BACK  = 2'd1; // every cell takes its newer neighbor
  localparam logic [1:0] MV_UPTO_BACK = 2'd2; // cells at or before slot take newer neighbor
  localparam logic [1:0] MV_FROM_FWD  = 2'd3; // cells at or after slot take older neighbor

  // Command broadcast to every cell
  typedef struct packed {
    logic                 match;
    logic                 apply;
    logic [1:0]           move;
    logic [SLOT_BITS-1:0] slot;
  } lrt_cmd_t;

endpackage

[rtl/core/lrt_req_if.sv]
interface lrt_req_if;
  import lrt_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key;

  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);

endinterface

[rtl/core/lrt_resp_if.sv]
interface lrt_resp_if;
  import lrt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    oldest_key;
  logic                oldest_valid;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output oldest_key, output oldest_valid,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input oldest_key, input oldest_valid,
                  input entry_count, output ready);

endinterface

[rtl/core/lrt_cell.sv]
module lrt_cell #(
  parameter int KEY_BITS = lrt_pkg::KEY_BITS_DEF,
  parameter int INDEX    = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  lrt_pkg::lrt_cmd_t   cmd,
  input  logic [KEY_BITS-1:0] cmp_key,
  input  logic [KEY_BITS-1:0] newer_key,
  input  logic                newer_valid,
  input  logic [KEY_BITS-1:0] older_key,
  input  logic                older_valid,
  output logic [KEY_BITS-1:0] key,
  output logic                valid,
  output logic                hit
);
  import lrt_pkg::*;

  localparam logic [SLOT_BITS-1:0] MY_SLOT = SLOT_BITS'(INDEX);

  logic take_newer;
  logic take_older;

  always_comb begin
    take_newer = 1'b0;
    take_older = 1'b0;
    unique case (cmd.move)
      MV_NONE:      ;
      MV_ALL_BACK:  take_newer = 1'b1;
      MV_UPTO_BACK: take_newer = (MY_SLOT <= cmd.slot);
      MV_FROM_FWD:  take_older = (MY_SLOT >= cmd.slot);
      default:      ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (cmd.match) begin
        hit <= valid && (key == cmp_key);
      end
      if (cmd.apply && take_newer) begin
        valid <= newer_valid;
      end else if (cmd.apply && take_older) begin
        valid <= older_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && take_newer) begin
      key <= newer_key;
    end else if (cmd.apply && take_older) begin
      key <= older_key;
    end
  end

endmodule

[rtl/core/lrt_hit_enc.sv]
module lrt_hit_enc #(
  parameter int ENTRIES = lrt_pkg::ENTRIES_DEF
) (
  input  logic [ENTRIES-1:0]            hits,
  output logic                          any_hit,
  output logic [lrt_pkg::SLOT_BITS-1:0] slot
);
  import lrt_pkg::*;

  // Keys are unique, so at most one hit is set and an OR of indexes is exact
  always_comb begin
    slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      slot = slot | (hits[i] ? SLOT_BITS'(i) : '0);
    end
    any_hit = |hits;
  end

endmodule

[rtl/core/lru_recency_tracker.sv]
// LRU recency tracker: keeps up to ENTRIES key tags in recency order, newest first.
// req channel (func, key): insert, touch to front, remove, or query the oldest key.
// resp channel: one item per request with status, the least recently used key,
// its valid flag and the number of keys held after the operation.
// Storage is a row of cells; slot 0 holds the newest key. After the accepting
// edge every cell compares the key in parallel, then the row shifts by the
// decoded move, then the oldest key, held in the last valid cell, is loaded into
// the output register and the result goes valid. A new request is accepted
// only once that result has been taken, so no request is taken while the last
// one is still in flight.
// While resp.ready is low the result holds and req.ready stays low.
// Reset (synchronous, rst high) empties the list and drops any pending result;
// keys wider than KEY_BITS lose their upper bits.
module lru_recency_tracker #(
  parameter int ENTRIES  = lrt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lrt_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lrt_req_if.sink     req,
  lrt_resp_if.source  resp
);
  import lrt_pkg::*;

  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int KW     = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;
  localparam int CW     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_MATCH  = 2'd1;
  localparam logic [1:0] S_APPLY  = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [FUNC_W-1:0]   func_r;
  logic [KEY_BITS-1:0] key_r;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_next;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [KEY_W-1:0]    out_key;
  logic                out_kvalid;
  logic [COUNT_W-1:0]  out_count;

  lrt_cmd_t            cmd;
  logic [1:0]          move_sel;
  logic                any_hit;
  logic [SLOT_BITS-1:0] hit_slot;

  logic [KEY_BITS-1:0] cell_key [ENTRIES];
  logic [ENTRIES-1:0]  cell_valid;
  logic [ENTRIES-1:0]  cell_hit;
  logic [ENTRIES-1:0]  is_last;
  logic [KEY_BITS-1:0] oldest;

  logic [KW-1:0]       key_in_wide;
  logic [KW-1:0]       oldest_wide;
  logic [CW-1:0]       count_wide;

  logic accept_in;

  assign accept_in   = req.valid && req.ready;
  assign req.ready   = (state == S_IDLE) && !out_valid;
  assign key_in_wide = KW'(req.key);

  // Decode the operation against the registered hit vector
  always_comb begin
    move_sel    = MV_NONE;
    count_next  = count;
    status_next = ST_OK;
    unique case (func_r)
      FUNC_INSERT: begin
        if (any_hit) begin
          status_next = ST_PRESENT;
        end else if (count == FULL_COUNT) begin
          status_next = ST_FULL;
        end else begin
          move_sel   = MV_ALL_BACK;
          count_next = count + CNT_W'(1);
        end
      end
      FUNC_TOUCH: begin
        if (any_hit) begin
          move_sel = MV_UPTO_BACK;
        end else begin
          status_next = ST_MISSING;
        end
      end
      FUNC_REMOVE: begin
        if (any_hit) begin
          move_sel   = MV_FROM_FWD;
          count_next = count - CNT_W'(1);
        end else begin
          status_next = ST_MISSING;
        end
      end
      FUNC_QUERY: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd.match = (state == S_MATCH);
    cmd.apply = (state == S_APPLY);
    cmd.move  = move_sel;
    cmd.slot  = hit_slot;
  end

  lrt_hit_enc #(
    .ENTRIES (ENTRIES)
  ) u_hit_enc (
    .hits    (cell_hit),
    .any_hit (any_hit),
    .slot    (hit_slot)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KEY_BITS-1:0] nk;
    logic                nv;
    logic [KEY_BITS-1:0] ok;
    logic                ov;
    if (i == 0) begin : g_head
      assign nk = key_r;
      assign nv = 1'b1;
    end else begin : g_mid
      assign nk = cell_key[i-1];
      assign nv = cell_valid[i-1];
    end
    if (i == ENTRIES - 1) begin : g_tail
      assign ok = '0;
      assign ov = 1'b0;
    end else begin : g_body
      assign ok = cell_key[i+1];
      assign ov = cell_valid[i+1];
    end

    lrt_cell #(
      .KEY_BITS (KEY_BITS),
      .INDEX    (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .cmp_key     (key_r),
      .newer_key   (nk),
      .newer_valid (nv),
      .older_key   (ok),
      .older_valid (ov),
      .key         (cell_key[i]),
      .valid       (cell_valid[i]),
      .hit         (cell_hit[i])
    );
  end

  // Valid cells are packed from slot 0, so the oldest is the last valid one
  assign is_last = cell_valid & ~{1'b0, cell_valid[ENTRIES-1:1]};

  always_comb begin
    oldest = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      oldest = oldest | (is_last[i] ? cell_key[i] : '0);
    end
  end

  assign oldest_wide = KW'(oldest);
  assign count_wide  = CW'(count);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept_in) state_next = S_MATCH;
      S_MATCH:  state_next = S_APPLY;
      S_APPLY:  state_next = S_RESULT;
      S_RESULT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_APPLY) begin
        count <= count_next;
      end
      if (state == S_RESULT) begin
        out_valid <= 1'b1;
      end else if (resp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      func_r <= req.func;
      key_r  <= key_in_wide[KEY_BITS-1:0];
    end
    if (state == S_APPLY) begin
      status_r <= status_next;
    end
    if (state == S_RESULT) begin
      out_status <= status_r;
      out_key    <= oldest_wide[KEY_W-1:0];
      out_kvalid <= (count != '0);
      out_count  <= count_wide[COUNT_W-1:0];
    end
  end

  assign resp.valid        = out_valid;
  assign resp.status       = out_status;
  assign resp.oldest_key   = out_key;
  assign resp.oldest_valid = out_kvalid;
  assign resp.entry_count  = out_count;

endmodule
